/* rtl/core/pmq_pkg.sv */
// ============================================================================
// pmq_pkg
// Shared types and codes of the priority message queue: operation codes,
// status codes and the command that the queue control broadcasts to the cells.
// ============================================================================
package pmq_pkg;

    localparam int PRIO_W   = 5;
    localparam int LEN_W    = 6;
    localparam int STATUS_W = 3;
    localparam int FIELD_W  = 64;

    localparam logic FUNC_SEND    = 1'b0;
    localparam logic FUNC_RECEIVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SMALL_BUF = 3'd4;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 6'd32;

    // Command seen by every cell in the same cycle.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [PRIO_W-1:0] prio;
        logic [LEN_W-1:0]  len;
    } pmq_cmd_t;

endpackage

/* rtl/core/pmq_cell.sv */
// ============================================================================
// pmq_cell
// One slot of the sorted chain. It keeps its message, takes the new message,
// or takes its left neighbor's message on a send, and takes its right
// neighbor's message on a receive.
// ============================================================================
module pmq_cell
    import pmq_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 64,
    parameter int CNT_W      = 6
) (
    input  logic                  clk,
    input  pmq_cmd_t              cmd,
    input  logic [DATA_WIDTH-1:0] new_data,
    input  logic [CNT_W-1:0]      count,
    input  logic                  left_keep,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [PRIO_W-1:0]     left_prio,
    input  logic [LEN_W-1:0]      left_len,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [PRIO_W-1:0]     right_prio,
    input  logic [LEN_W-1:0]      right_len,
    output logic                  keep,
    output logic [DATA_WIDTH-1:0] data,
    output logic [PRIO_W-1:0]     prio,
    output logic [LEN_W-1:0]      len
);

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [PRIO_W-1:0]     prio_reg, prio_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  occupied;

    assign occupied = (count > CNT_W'(INDEX));

    // An occupied slot whose priority is at least the new one stays put.
    assign keep = occupied && (prio_reg >= cmd.prio);

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        len_next  = len_reg;
        if (cmd.push)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    data_next = new_data;
                    prio_next = cmd.prio;
                    len_next  = cmd.len;
                end
                else
                begin
                    data_next = left_data;
                    prio_next = left_prio;
                    len_next  = left_len;
                end
            end
        end
        else if (cmd.pop)
        begin
            data_next = right_data;
            prio_next = right_prio;
            len_next  = right_len;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
        len_reg  <= len_next;
    end

    assign data = data_reg;
    assign prio = prio_reg;
    assign len  = len_reg;

endmodule

/* rtl/core/priority_message_queue_top.sv */
// ============================================================================
// priority_message_queue_top
// Each result is registered and reaches the output in the cycle after its input transfer.
// Throughput: one item per cycle while the output does not stall; every cell updates in the same cycle.
// Reset clears the count, the output valid and sets max_length to 32.
// Message slots are not cleared; only slots below the count are read.
// ============================================================================
module priority_message_queue_top
    import pmq_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    // Configuration port for max_length.
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,
    // Input channel.
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [FIELD_W-1:0]  msg_data,
    input  logic [LEN_W-1:0]    msg_length,
    input  logic [PRIO_W-1:0]   msg_priority,
    // Output channel.
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [FIELD_W-1:0]  out_data,
    output logic [LEN_W-1:0]    out_length,
    output logic [PRIO_W-1:0]   out_priority,
    output logic [LEN_W-1:0]    entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // The queue is a row of DEPTH cells with the head in cell 0. The cells are
    // kept sorted by descending priority, oldest first within a priority. On a
    // send every cell compares its own priority with the new one in parallel;
    // the first cell that does not keep its message takes the new one and all
    // cells behind it take their left neighbor's message. On a receive every
    // cell takes its right neighbor's message, which pops the head.

    logic [LEN_W-1:0]      max_length_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [FIELD_W-1:0]    out_data_reg;
    logic [LEN_W-1:0]      out_length_reg;
    logic [PRIO_W-1:0]     out_priority_reg;

    logic                  accept;
    logic                  too_long, full, small_buf, empty;
    logic [STATUS_W-1:0]   status_next;
    logic [DATA_WIDTH-1:0] data_in;
    logic [DATA_WIDTH+FIELD_W-1:0] head_data_ext;
    logic [CNT_W+LEN_W-1:0]        count_ext;
    pmq_cmd_t              cmd;

    logic                  cell_keep [DEPTH];
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [PRIO_W-1:0]     cell_prio [DEPTH];
    logic [LEN_W-1:0]      cell_len  [DEPTH];

    // The output register parts the two sides: a new transfer is taken
    // whenever the pending result is gone or leaves in this cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Sends check the length before the fill level; receives check the
    // buffer capacity before emptiness.
    assign too_long  = (msg_length > max_length_reg);
    assign small_buf = (msg_length < max_length_reg);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    assign data_in = msg_data[DATA_WIDTH-1:0];

    always_comb
    begin
        cmd.push = 1'b0;
        cmd.pop  = 1'b0;
        cmd.prio = msg_priority;
        cmd.len  = msg_length;
        status_next = ST_OK;
        if (func == FUNC_SEND)
        begin
            if (too_long)
            begin
                status_next = ST_TOO_LONG;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                cmd.push = accept;
            end
        end
        else
        begin
            if (small_buf)
            begin
                status_next = ST_SMALL_BUF;
            end
            else if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                cmd.pop = accept;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                  l_keep;
            logic [DATA_WIDTH-1:0] l_data, r_data;
            logic [PRIO_W-1:0]     l_prio, r_prio;
            logic [LEN_W-1:0]      l_len, r_len;

            // The head has nothing to its left, so it behaves as if its
            // left neighbor kept its message.
            if (gi == 0)
            begin : g_left_edge
                assign l_keep = 1'b1;
                assign l_data = data_in;
                assign l_prio = msg_priority;
                assign l_len  = msg_length;
            end
            else
            begin : g_left
                assign l_keep = cell_keep[gi-1];
                assign l_data = cell_data[gi-1];
                assign l_prio = cell_prio[gi-1];
                assign l_len  = cell_len[gi-1];
            end

            // The tail refills from itself on a receive; it is then beyond
            // the count and never read.
            if (gi == DEPTH - 1)
            begin : g_right_edge
                assign r_data = cell_data[gi];
                assign r_prio = cell_prio[gi];
                assign r_len  = cell_len[gi];
            end
            else
            begin : g_right
                assign r_data = cell_data[gi+1];
                assign r_prio = cell_prio[gi+1];
                assign r_len  = cell_len[gi+1];
            end

            pmq_cell #(
                .INDEX      (gi),
                .DATA_WIDTH (DATA_WIDTH),
                .CNT_W      (CNT_W)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .new_data   (data_in),
                .count      (count_reg),
                .left_keep  (l_keep),
                .left_data  (l_data),
                .left_prio  (l_prio),
                .left_len   (l_len),
                .right_data (r_data),
                .right_prio (r_prio),
                .right_len  (r_len),
                .keep       (cell_keep[gi]),
                .data       (cell_data[gi]),
                .prio       (cell_prio[gi]),
                .len        (cell_len[gi])
            );
        end
    endgenerate

    assign head_data_ext = {{FIELD_W{1'b0}}, cell_data[0]};

    // Control state: count, max_length and the output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_length_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: the head is captured before the pop shifts it out.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            if (cmd.pop)
            begin
                out_data_reg     <= head_data_ext[FIELD_W-1:0];
                out_length_reg   <= cell_len[0];
                out_priority_reg <= cell_prio[0];
            end
            else
            begin
                out_data_reg     <= '0;
                out_length_reg   <= '0;
                out_priority_reg <= '0;
            end
        end
    end

    // The count is reported modulo 64 when the queue can hold 64 or more messages.
    assign count_ext = {{LEN_W{1'b0}}, count_reg};

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_data     = out_data_reg;
    assign out_length   = out_length_reg;
    assign out_priority = out_priority_reg;
    assign entry_count  = count_ext[LEN_W-1:0];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds queue depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("send did not grow the count by one");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("receive did not shrink the count by one");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("send and receive issued together");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)
                                      && $stable(entry_count)))
        else $error("pending result lost while the output was stalled");
`endif

endmodule
